// ===== hw/rtl/rtpv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpv_pkg
// Shared types and constants of the raw-video RTP depacketizer.
// ----------------------------------------------------------------------------
package rtpv_pkg;

   localparam int MAX_LINES_DEF = 16;
   localparam int ADDR_BITS_DEF = 26;

   // configuration register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BPP          = 2'd2;
   localparam logic [1:0] CSR_PAYLOAD_TYPE = 2'd3;

   // packet status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_HDR  = 2'd1;
   localparam logic [1:0] ST_TOO_MANY = 2'd2;
   localparam logic [1:0] ST_TRUNC    = 2'd3;

   localparam logic [1:0] RTP_VERSION = 2'd2;

   // fixed header byte positions
   localparam logic [3:0] POS_PT_BYTE  = 4'd1;
   localparam logic [3:0] POS_RTP_LAST = 4'd11;
   localparam logic [3:0] POS_EXT_LAST = 4'd13;
   localparam logic [3:0] POS_SAT      = 4'd15;

   // line header byte positions
   localparam logic [15:0] LH_LINE_DONE = 16'd3;
   localparam logic [15:0] LH_LAST      = 16'd5;

   typedef enum logic [2:0] {
      PH_RTP  = 3'd0,
      PH_EXT  = 3'd1,
      PH_LINE = 3'd2,
      PH_PAY  = 3'd3,
      PH_SKIP = 3'd4
   } phase_type;

   // configuration with derived products
   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [2:0]  bpp;
      logic [6:0]  payload_type;
      logic [15:0] stride;      // width * bpp
      logic [31:0] frame_size;  // width * height * bpp
   } cfg_type;

endpackage

// ===== hw/rtl/rtpv_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpv_csr
// Configuration registers and the registered line stride and frame size.
// ----------------------------------------------------------------------------
module rtpv_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [12:0]     csr_data,
   output rtpv_pkg::cfg_type cfg
);

   logic [12:0] width_ff, height_ff;
   logic [2:0]  bpp_ff;
   logic [6:0]  pt_ff;
   logic [15:0] stride_ff;
   logic [25:0] wh_ff;
   logic [31:0] fsize_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         bpp_ff    <= 3'd3;
         pt_ff     <= 7'd96;
      end else if (csr_wr_en) begin
         case (csr_index)
            rtpv_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            rtpv_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data;
            rtpv_pkg::CSR_BPP:          bpp_ff    <= csr_data[2:0];
            rtpv_pkg::CSR_PAYLOAD_TYPE: pt_ff     <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // derived products, two stages for the frame size
   always_ff @(posedge clock) begin
      stride_ff <= 16'(width_ff * bpp_ff);
      wh_ff     <= 26'(width_ff * height_ff);
      fsize_ff  <= 32'(wh_ff * bpp_ff);
   end

   assign cfg = '{frame_width: width_ff, frame_height: height_ff, bpp: bpp_ff,
                  payload_type: pt_ff, stride: stride_ff, frame_size: fsize_ff};

endmodule

// ===== hw/rtl/rtpv_line_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpv_line_table
// Per-packet line headers with precomputed base addresses, and the search
// for the next line that carries bytes.
// ----------------------------------------------------------------------------
module rtpv_line_table #(
   parameter int MAX_LINES = rtpv_pkg::MAX_LINES_DEF,
   localparam int LC_W  = $clog2(MAX_LINES + 1),
   localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
   input  logic             clock,
   // first write: length, line flags and line base
   input  logic             wr_head,
   input  logic [IDX_W-1:0] wr_head_idx,
   input  logic [15:0]      wr_len,
   input  logic             wr_line_zero,
   input  logic             wr_line_ok,
   input  logic [33:0]      wr_base,
   // second write: add the pixel offset
   input  logic             wr_off,
   input  logic [IDX_W-1:0] wr_off_idx,
   input  logic [17:0]      wr_off_bytes,
   // read port
   input  logic [IDX_W-1:0] rd_idx,
   output logic [15:0]      rd_len,
   output logic             rd_line_ok,
   output logic [33:0]      rd_base,
   // search
   input  logic [LC_W-1:0]  srch_start,
   input  logic [LC_W-1:0]  srch_count,
   output logic             srch_found,
   output logic             srch_stop,
   output logic [LC_W-1:0]  srch_idx
);

   logic [15:0] len_ff  [MAX_LINES];
   logic [33:0] base_ff [MAX_LINES];
   logic [MAX_LINES-1:0] zero_ff, ok_ff, nz_ff;

   // entry writes
   always_ff @(posedge clock) begin
      if (wr_head) begin
         len_ff[wr_head_idx]  <= wr_len;
         base_ff[wr_head_idx] <= wr_base;
         zero_ff[wr_head_idx] <= wr_line_zero;
         ok_ff[wr_head_idx]   <= wr_line_ok;
         nz_ff[wr_head_idx]   <= (wr_len != 16'd0);
      end
      if (wr_off) begin
         base_ff[wr_off_idx] <= base_ff[wr_off_idx] + 34'(wr_off_bytes);
      end
   end

   assign rd_len     = len_ff[rd_idx];
   assign rd_line_ok = ok_ff[rd_idx];
   assign rd_base    = base_ff[rd_idx];

   // first entry in [start, count) that is line zero or has bytes
   always_comb begin
      srch_found = 1'b0;
      srch_stop  = 1'b0;
      srch_idx   = '0;
      for (int i = 0; i < MAX_LINES; i++) begin
         if (!srch_found && LC_W'(i) >= srch_start && LC_W'(i) < srch_count &&
             (zero_ff[i] || nz_ff[i])) begin
            srch_found = 1'b1;
            srch_stop  = zero_ff[i];
            srch_idx   = LC_W'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/rtp_raw_video_depacketizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_raw_video_depacketizer_unit
// Parses RTP raw-video packets byte by byte and issues frame-buffer writes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_byte, req_last
//  rsp     | out       | rsp_valid/rsp_stall | write, address, data, packet status
//  csr     | in        | csr_wr_en           | csr_index, csr_data
//
// One request per cycle; a result, if any, appears in the output register on
// the cycle after acceptance. Line base addresses are computed while the line
// headers arrive, so payload bytes need only one add and compare each.
// Synchronous reset clears all control state. Requests stall only while the
// output register holds a result that the receiver stalls.
// ----------------------------------------------------------------------------
module rtp_raw_video_depacketizer_unit #(
   parameter int MAX_LINES = rtpv_pkg::MAX_LINES_DEF,
   parameter int ADDR_BITS = rtpv_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_wr_en,
   output logic [25:0] rsp_wr_addr,
   output logic [7:0]  rsp_wr_data,
   output logic        rsp_packet_end,
   output logic [1:0]  rsp_packet_status,
   output logic        rsp_frame_end,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int LC_W  = $clog2(MAX_LINES + 1);
   localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam logic [LC_W-1:0] LC_MAX = LC_W'(MAX_LINES);
   localparam logic [34:0] ADDR_LIMIT = 35'(1) << ADDR_BITS;

   rtpv_pkg::cfg_type cfg;

   rtpv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // parser state
   rtpv_pkg::phase_type phase_ff, phase_in;
   logic [3:0]      pos_ff, pos_in;
   logic [23:0]     shift_ff, shift_in;
   logic            hdr_ok_ff, hdr_ok_in;
   logic            marker_ff, marker_in;
   logic [LC_W-1:0] lcnt_ff, lcnt_in;
   logic [LC_W-1:0] lidx_ff, lidx_in;
   logic [15:0]     lbc_ff, lbc_in;
   logic [1:0]      err_ff, err_in;

   // output register
   logic        rsp_valid_ff;
   logic        wr_en_ff, pend_ff, fend_ff;
   logic [25:0] addr_ff;
   logic [7:0]  data_ff;
   logic [1:0]  status_ff;

   logic accept;
   logic wr;
   logic [34:0] addr;
   logic [1:0]  status;
   logic        fend;

   // line table interface
   logic             t_wr_head, t_wr_off;
   logic [IDX_W-1:0] t_wr_idx;
   logic [14:0]      line_num, off_num;
   logic [33:0]      line_base;
   logic [17:0]      off_bytes;
   logic [15:0]      t_len;
   logic             t_line_ok;
   logic [33:0]      t_base;
   logic [LC_W-1:0]  s_start, s_count, s_idx;
   logic             s_found, s_stop;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // line fields and their precomputed byte offsets
   assign line_num  = {shift_ff[6:0], req_byte};
   assign off_num   = {shift_ff[6:0], req_byte};
   assign line_base = 34'(15'(line_num - 15'd1) * cfg.stride);
   assign off_bytes = 18'(off_num * cfg.bpp);
   assign t_wr_idx  = lcnt_ff[IDX_W-1:0];

   rtpv_line_table #(.MAX_LINES(MAX_LINES)) u_table (
      .clock        (clock),
      .wr_head      (t_wr_head),
      .wr_head_idx  (t_wr_idx),
      .wr_len       (shift_ff[23:8]),
      .wr_line_zero (line_num == 15'd0),
      .wr_line_ok   ({2'b00, line_num} <= {4'b0000, cfg.frame_height}),
      .wr_base      (line_base),
      .wr_off       (t_wr_off),
      .wr_off_idx   (t_wr_idx),
      .wr_off_bytes (off_bytes),
      .rd_idx       (lidx_ff[IDX_W-1:0]),
      .rd_len       (t_len),
      .rd_line_ok   (t_line_ok),
      .rd_base      (t_base),
      .srch_start   (s_start),
      .srch_count   (s_count),
      .srch_found   (s_found),
      .srch_stop    (s_stop),
      .srch_idx     (s_idx)
   );

   // parse one byte
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = (pos_ff == rtpv_pkg::POS_SAT) ? pos_ff : pos_ff + 4'd1;
      shift_in  = shift_ff;
      hdr_ok_in = hdr_ok_ff;
      marker_in = marker_ff;
      lcnt_in   = lcnt_ff;
      lidx_in   = lidx_ff;
      lbc_in    = lbc_ff;
      err_in    = err_ff;
      wr        = 1'b0;
      addr      = 35'(t_base) + 35'(lbc_ff);
      t_wr_head = 1'b0;
      t_wr_off  = 1'b0;
      s_start   = '0;
      s_count   = lcnt_ff;

      case (phase_ff)
         rtpv_pkg::PH_RTP: begin
            shift_in = {shift_ff[15:0], req_byte};
            if (pos_ff == rtpv_pkg::POS_PT_BYTE) begin
               if (shift_ff[7:6] == rtpv_pkg::RTP_VERSION &&
                   req_byte[6:0] == cfg.payload_type) begin
                  hdr_ok_in = 1'b1;
                  marker_in = req_byte[7];
               end else begin
                  err_in   = rtpv_pkg::ST_BAD_HDR;
                  phase_in = rtpv_pkg::PH_SKIP;
               end
            end
            if (pos_ff == rtpv_pkg::POS_RTP_LAST) phase_in = rtpv_pkg::PH_EXT;
         end
         rtpv_pkg::PH_EXT: begin
            if (pos_ff == rtpv_pkg::POS_EXT_LAST) begin
               phase_in = rtpv_pkg::PH_LINE;
               lbc_in   = '0;
            end
         end
         rtpv_pkg::PH_LINE: begin
            shift_in = {shift_ff[15:0], req_byte};
            if (lcnt_ff >= LC_MAX) begin
               err_in   = rtpv_pkg::ST_TOO_MANY;
               phase_in = rtpv_pkg::PH_SKIP;
            end else begin
               if (lbc_ff == rtpv_pkg::LH_LINE_DONE) t_wr_head = accept;
               if (lbc_ff == rtpv_pkg::LH_LAST) begin
                  t_wr_off = accept;
                  lcnt_in  = lcnt_ff + LC_W'(1);
                  lbc_in   = '0;
                  if (shift_ff[7]) begin
                     if (lcnt_in >= LC_MAX) begin
                        err_in   = rtpv_pkg::ST_TOO_MANY;
                        phase_in = rtpv_pkg::PH_SKIP;
                     end
                  end else begin
                     s_start  = '0;
                     s_count  = lcnt_in;
                     lidx_in  = s_idx;
                     phase_in = (s_found && !s_stop) ? rtpv_pkg::PH_PAY
                                                     : rtpv_pkg::PH_SKIP;
                  end
               end else begin
                  lbc_in = lbc_ff + 16'd1;
               end
            end
         end
         rtpv_pkg::PH_PAY: begin
            wr = t_line_ok && (addr < 35'(cfg.frame_size)) && (addr < ADDR_LIMIT);
            lbc_in = lbc_ff + 16'd1;
            if ({1'b0, lbc_ff} + 17'd1 >= {1'b0, t_len}) begin
               lbc_in   = '0;
               s_start  = lidx_ff + LC_W'(1);
               s_count  = lcnt_ff;
               lidx_in  = s_idx;
               phase_in = (s_found && !s_stop) ? rtpv_pkg::PH_PAY
                                               : rtpv_pkg::PH_SKIP;
            end
         end
         default: ;
      endcase

      // end of packet status
      if (err_in != rtpv_pkg::ST_OK)       status = err_in;
      else if (phase_in != rtpv_pkg::PH_SKIP) status = rtpv_pkg::ST_TRUNC;
      else                                 status = rtpv_pkg::ST_OK;
      fend = (status == rtpv_pkg::ST_OK) && hdr_ok_in && marker_in;

      if (req_last) begin
         phase_in  = rtpv_pkg::PH_RTP;
         pos_in    = '0;
         shift_in  = '0;
         hdr_ok_in = 1'b0;
         marker_in = 1'b0;
         lcnt_in   = '0;
         lidx_in   = '0;
         lbc_in    = '0;
         err_in    = rtpv_pkg::ST_OK;
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rtpv_pkg::PH_RTP;
         pos_ff    <= '0;
         shift_ff  <= '0;
         hdr_ok_ff <= 1'b0;
         marker_ff <= 1'b0;
         lcnt_ff   <= '0;
         lidx_ff   <= '0;
         lbc_ff    <= '0;
         err_ff    <= rtpv_pkg::ST_OK;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         hdr_ok_ff <= hdr_ok_in;
         marker_ff <= marker_in;
         lcnt_ff   <= lcnt_in;
         lidx_ff   <= lidx_in;
         lbc_ff    <= lbc_in;
         err_ff    <= err_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && (wr || req_last)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (wr || req_last)) begin
         wr_en_ff  <= wr;
         addr_ff   <= wr ? addr[25:0] : 26'd0;
         data_ff   <= wr ? req_byte : 8'd0;
         pend_ff   <= req_last;
         status_ff <= req_last ? status : rtpv_pkg::ST_OK;
         fend_ff   <= req_last & fend;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wr_en         = wr_en_ff;
   assign rsp_wr_addr       = addr_ff;
   assign rsp_wr_data       = data_ff;
   assign rsp_packet_end    = pend_ff;
   assign rsp_packet_status = status_ff;
   assign rsp_frame_end     = fend_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RTP raw-video depacketizer. Packets are built
// as byte requests (good, bad header, truncated, too many lines, line zero,
// noise), a behavioral frame-write predictor computes the expected writes
// and packet status, and every response is compared field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int NLINES = rtpv_pkg::MAX_LINES_DEF;

   typedef struct packed {
      logic        wr_en;
      logic [25:0] wr_addr;
      logic [7:0]  wr_data;
      logic        packet_end;
      logic [1:0]  packet_status;
      logic        frame_end;
   } fb_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_wr_en;
   logic [25:0] rsp_wr_addr;
   logic [7:0]  rsp_wr_data;
   logic        rsp_packet_end;
   logic [1:0]  rsp_packet_status;
   logic        rsp_frame_end;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   rtp_raw_video_depacketizer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_byte(req_byte), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_wr_en(rsp_wr_en), .rsp_wr_addr(rsp_wr_addr),
      .rsp_wr_data(rsp_wr_data), .rsp_packet_end(rsp_packet_end),
      .rsp_packet_status(rsp_packet_status), .rsp_frame_end(rsp_frame_end),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // predictor configuration and per-packet state
   logic [12:0]  m_width = 13'd640, m_height = 13'd480;
   logic [2:0]   m_bpp = 3'd3;
   logic [6:0]   m_ptype = 7'd96;
   logic [15:0]  m_pos;
   logic [31:0]  m_shift;
   logic         m_hdr_ok, m_marker, m_stopped;
   logic [15:0]  m_len  [NLINES];
   logic [14:0]  m_line [NLINES];
   logic [14:0]  m_off  [NLINES];
   int unsigned  m_count, m_index, m_lbc;
   rtpv_pkg::phase_type m_phase;
   logic [1:0]   m_err;

   fb_write_type expected_writes[$];
   int           n_fail = 0;
   int           n_results = 0;
   int           n_sent = 0;
   bit           slow_rx = 1'b0;

   function automatic void clear_packet();
      m_pos = '0; m_shift = '0; m_hdr_ok = 1'b0; m_marker = 1'b0; m_count = 0;
      m_index = 0; m_lbc = 0; m_phase = rtpv_pkg::PH_RTP; m_stopped = 1'b0;
      m_err = '0;
   endfunction

   // move to the next line with bytes, or leave the payload phase
   function automatic void next_line();
      while (!m_stopped && m_index < m_count && m_index < NLINES) begin
         if (m_line[m_index] == 0) begin
            m_stopped = 1'b1;
            break;
         end
         if (m_len[m_index] != 0) break;
         m_index++;
      end
      m_phase = (m_stopped || m_index >= m_count || m_index >= NLINES) ?
                rtpv_pkg::PH_SKIP : rtpv_pkg::PH_PAY;
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      fb_write_type r;
      logic [63:0]  addr, fsize, ln;
      logic [31:0]  w;
      logic         wr;
      wr = 1'b0;
      addr = '0;
      case (m_phase)
         rtpv_pkg::PH_RTP: begin
            m_shift = {m_shift[23:0], b};
            if (m_pos == 1) begin
               w = {m_shift[15:0], 16'h0};
               if (w[31:30] == rtpv_pkg::RTP_VERSION && w[22:16] == m_ptype) begin
                  m_hdr_ok = 1'b1;
                  m_marker = w[23];
               end else begin
                  m_err = rtpv_pkg::ST_BAD_HDR;
                  m_phase = rtpv_pkg::PH_SKIP;
               end
            end
            if (m_pos == 11) m_phase = rtpv_pkg::PH_EXT;
         end
         rtpv_pkg::PH_EXT: begin
            if (m_pos == 13) begin
               m_phase = rtpv_pkg::PH_LINE;
               m_lbc = 0;
            end
         end
         rtpv_pkg::PH_LINE: begin
            m_shift = {m_shift[23:0], b};
            if (m_count >= NLINES) begin
               m_err = rtpv_pkg::ST_TOO_MANY;
               m_phase = rtpv_pkg::PH_SKIP;
            end else begin
               if (m_lbc == 3) begin
                  m_len[m_count] = m_shift[31:16];
                  m_line[m_count] = m_shift[14:0];
               end
               if (m_lbc == 5) begin
                  m_off[m_count] = m_shift[14:0];
                  m_count++;
                  m_lbc = 0;
                  if (m_shift[15]) begin
                     if (m_count >= NLINES) begin
                        m_err = rtpv_pkg::ST_TOO_MANY;
                        m_phase = rtpv_pkg::PH_SKIP;
                     end
                  end else begin
                     m_index = 0;
                     next_line();
                  end
               end else begin
                  m_lbc++;
               end
            end
         end
         rtpv_pkg::PH_PAY: begin
            ln = 64'(m_line[m_index % NLINES]);
            fsize = 64'(m_width) * m_height * m_bpp;
            addr = 64'(m_off[m_index % NLINES]) * m_bpp + (ln - 1) * (64'(m_width) * m_bpp)
                   + m_lbc;
            if (ln <= m_height && addr < fsize && addr < (64'd1 << 26)) wr = 1'b1;
            m_lbc++;
            if (m_lbc >= m_len[m_index % NLINES]) begin
               m_lbc = 0;
               m_index++;
               next_line();
            end
         end
         default: ;
      endcase
      if (m_pos < 16'hFFFF) m_pos++;
      if (!wr && !last) return;
      r = '0;
      r.wr_en = wr;
      r.wr_addr = wr ? addr[25:0] : '0;
      r.wr_data = wr ? b : '0;
      r.packet_end = last;
      if (last) begin
         if (m_err != 0) r.packet_status = m_err;
         else if (m_phase != rtpv_pkg::PH_SKIP) r.packet_status = rtpv_pkg::ST_TRUNC;
         else r.packet_status = rtpv_pkg::ST_OK;
         r.frame_end = (r.packet_status == rtpv_pkg::ST_OK && m_hdr_ok && m_marker);
         clear_packet();
      end
      expected_writes.push_back(r);
   endfunction

   // response checker and random receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected response");
            n_fail++;
         end else begin
            fb_write_type e;
            e = expected_writes.pop_front();
            n_results++;
            if (rsp_wr_en !== e.wr_en) begin
               $error("wr_en exp %0h got %0h", e.wr_en, rsp_wr_en); n_fail++;
            end
            if (rsp_wr_addr !== e.wr_addr) begin
               $error("wr_addr exp %0h got %0h", e.wr_addr, rsp_wr_addr); n_fail++;
            end
            if (rsp_wr_data !== e.wr_data) begin
               $error("wr_data exp %0h got %0h", e.wr_data, rsp_wr_data); n_fail++;
            end
            if (rsp_packet_end !== e.packet_end) begin
               $error("packet_end exp %0h got %0h", e.packet_end, rsp_packet_end); n_fail++;
            end
            if (rsp_packet_status !== e.packet_status) begin
               $error("packet_status exp %0h got %0h", e.packet_status, rsp_packet_status);
               n_fail++;
            end
            if (rsp_frame_end !== e.frame_end) begin
               $error("frame_end exp %0h got %0h", e.frame_end, rsp_frame_end); n_fail++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (slow_rx) rsp_stall <= ($urandom_range(0, 9) < 3) ||
                                ($urandom_range(0, 99) == 0);
      else rsp_stall <= 1'b0;
   end

   // send one request byte, with an optional random gap before it
   task automatic send_byte(input logic [7:0] b, input logic last, input bit gaps);
      int g;
      if (gaps) begin
         g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) g = 0;
         if (g > 0) begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_byte  <= b;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(b, last);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      int t;
      req_valid <= 1'b0;
      t = 0;
      while (expected_writes.size() != 0 && t < 100000) begin
         @(negedge clock);
         t++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [12:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         rtpv_pkg::CSR_FRAME_WIDTH:  m_width = val;
         rtpv_pkg::CSR_FRAME_HEIGHT: m_height = val;
         rtpv_pkg::CSR_BPP:          m_bpp = val[2:0];
         rtpv_pkg::CSR_PAYLOAD_TYPE: m_ptype = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_format(input logic [12:0] w, input logic [12:0] h,
                             input logic [2:0] bpp, input logic [6:0] pt);
      go_idle();
      write_csr(rtpv_pkg::CSR_FRAME_WIDTH, w);
      write_csr(rtpv_pkg::CSR_FRAME_HEIGHT, h);
      write_csr(rtpv_pkg::CSR_BPP, 13'(bpp));
      write_csr(rtpv_pkg::CSR_PAYLOAD_TYPE, 13'(pt));
   endtask

   // one line header descriptor
   typedef struct {
      logic [15:0] len;
      logic        fbit;
      logic [14:0] line;
      logic [14:0] off;
   } line_desc_type;

   // build and send a packet; cut > 0 truncates it to that many bytes
   task automatic send_packet(input logic [1:0] ver, input logic [6:0] pt,
                              input logic marker, input line_desc_type lines[$],
                              input int extra, input int cut, input bit gaps);
      logic [7:0] pkt[$];
      int         total;
      total = 0;
      pkt.push_back({ver, 6'($urandom)});
      pkt.push_back({marker, pt});
      repeat (12) pkt.push_back(8'($urandom));
      foreach (lines[i]) begin
         pkt.push_back(lines[i].len[15:8]);
         pkt.push_back(lines[i].len[7:0]);
         pkt.push_back({lines[i].fbit, lines[i].line[14:8]});
         pkt.push_back(lines[i].line[7:0]);
         pkt.push_back({i != lines.size() - 1, lines[i].off[14:8]});
         pkt.push_back(lines[i].off[7:0]);
      end
      foreach (lines[i]) total += lines[i].len;
      repeat (total + extra) pkt.push_back(8'($urandom));
      if (cut > 0 && cut < pkt.size()) pkt = pkt[0:cut-1];
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, gaps);
   endtask

   function automatic line_desc_type rand_line(input int maxlen);
      line_desc_type d;
      d.len = 16'($urandom_range(0, maxlen));
      d.fbit = 1'($urandom);
      d.line = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(1, 20));
      d.off = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 40));
      return d;
   endfunction

   function automatic line_desc_type mk_line(input int len, input int line, input int off);
      line_desc_type d;
      d.len = 16'(len); d.fbit = 1'b0; d.line = 15'(line); d.off = 15'(off);
      return d;
   endfunction

   task automatic test_directed();
      line_desc_type q[$];
      set_format(13'd16, 13'd8, 3'd2, 7'd96);
      // good packet with marker, two lines
      q = {mk_line(3, 1, 0), mk_line(2, 8, 15)};
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 0, 0);
      // bad version, then bad payload type
      send_packet(2'd1, 7'd96, 1'b1, q, 0, 0, 0);
      send_packet(rtpv_pkg::RTP_VERSION, 7'd97, 1'b0, q, 0, 0, 0);
      // line too high, zero-length line, trailing bytes
      q = {mk_line(2, 9, 0), mk_line(0, 2, 0), mk_line(2, 2, 1)};
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b0, q, 3, 0, 0);
      // line zero stops writes
      q = {mk_line(2, 1, 0), mk_line(3, 0, 0), mk_line(2, 3, 0)};
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 0, 0);
      // outside frame (second line's number and offset lie past the frame)
      q = {mk_line(4, 8, 14), mk_line(1, 16'h7FFF, 16'h7FFF)};
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 0, 0);
      // truncated in RTP header, in ext seq, in line header, in data
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 1, 0);
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 13, 0);
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 17, 0);
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 28, 0);
      // too many lines
      q = {};
      repeat (NLINES + 1) q.push_back(mk_line(1, 1, 0));
      send_packet(rtpv_pkg::RTP_VERSION, 7'd96, 1'b1, q, 0, 0, 0);
      // all bits of a byte high and low
      send_byte(8'hFF, 1'b0, 0);
      send_byte(8'h00, 1'b1, 0);
   endtask

   task automatic test_random_packets(input int n_bytes);
      line_desc_type q[$];
      int            start, nl, r, cut;
      logic [1:0]    ver;
      logic [6:0]    pt;
      start = n_sent;
      while (n_sent - start < n_bytes) begin
         q = {};
         r = $urandom_range(0, 99);
         nl = (r < 3) ? $urandom_range(NLINES - 1, NLINES + 1) : $urandom_range(1, 4);
         repeat (nl) q.push_back(rand_line(8));
         if ($urandom_range(0, 9) == 0) q[$urandom_range(0, nl - 1)].line = '0;
         ver = ($urandom_range(0, 15) == 0) ? 2'($urandom) : rtpv_pkg::RTP_VERSION;
         pt = ($urandom_range(0, 15) == 0) ? 7'($urandom) : m_ptype;
         cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0;
         if ($urandom_range(0, 29) == 0) begin
            // noise burst
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 1'b0, 1);
            send_byte(8'($urandom), 1'b1, 1);
         end else begin
            send_packet(ver, pt, 1'($urandom), q, $urandom_range(0, 2), cut, 1);
         end
      end
   endtask

   task automatic test_drain_pause();
      line_desc_type q[$];
      q = {mk_line(6, 1, 0)};
      send_packet(rtpv_pkg::RTP_VERSION, m_ptype, 1'b1, q, 0, 0, 1);
      go_idle();
      send_packet(rtpv_pkg::RTP_VERSION, m_ptype, 1'b0, q, 0, 0, 0);
   endtask

   initial begin
      clear_packet();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      slow_rx = 1'b1;
      test_random_packets(160);
      set_format(13'd4096, 13'd4096, 3'd4, 7'd127);
      test_random_packets(130);
      set_format(13'd1, 13'd1, 3'd1, 7'd0);
      test_random_packets(90);
      set_format(13'd0, 13'd5, 3'd7, 7'd96);
      test_random_packets(90);
      set_format(13'd20, 13'd20, 3'd3, 7'd45);
      test_drain_pause();
      slow_rx = 1'b0;
      test_random_packets(130);
      slow_rx = 1'b1;
      set_format(13'd33, 13'd12, 3'd2, 7'd96);
      test_random_packets(200);
      go_idle();
      repeat (10) @(negedge clock);
      if (n_fail == 0 && expected_writes.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
